[rtl/core/ps2kd_pkg.sv]
// Package for the PS/2 set 2 key decoder: types, byte codes and modifier lookup.
`default_nettype none
package ps2kd_pkg;

  // Scan code bytes
  localparam logic [7:0] CODE_E0    = 8'hE0;
  localparam logic [7:0] CODE_F0    = 8'hF0;
  localparam logic [7:0] CODE_E1    = 8'hE1;
  localparam logic [7:0] CODE_F7    = 8'h83;
  localparam logic [7:0] CODE_7E    = 8'h7E;
  localparam logic [7:0] CODE_77    = 8'h77;
  localparam logic [7:0] CODE_14    = 8'h14;
  localparam logic [7:0] CODE_12    = 8'h12;
  localparam logic [7:0] CODE_11    = 8'h11;
  localparam logic [7:0] CODE_59    = 8'h59;
  localparam logic [7:0] CODE_1F    = 8'h1F;
  localparam logic [7:0] CODE_27    = 8'h27;

  // Direct HID usages
  localparam logic [7:0] USAGE_F7    = 8'h40;
  localparam logic [7:0] USAGE_PAUSE = 8'h48;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_F0   = 4'd1,
    PH_E0   = 4'd2,
    PH_E0F0 = 4'd3,
    PH_P1   = 4'd4,
    PH_P2   = 4'd5,
    PH_P3   = 4'd6,
    PH_P4   = 4'd7,
    PH_P5   = 4'd8,
    PH_P6   = 4'd9,
    PH_P7   = 4'd10,
    PH_C1   = 4'd11,
    PH_C2   = 4'd12,
    PH_C3   = 4'd13
  } phase_t;

  typedef struct packed {
    logic       new_key;
    logic [7:0] key_code;
    logic       key_extended;
    logic       key_direct;
    logic [7:0] modifier_mask;
  } result_t;

  // HID modifier bit for a set 2 code, plain or after E0
  function automatic logic [7:0] mod_bit_of(input logic [7:0] code, input logic ext);
    logic [7:0] bits;
    bits = 8'h00;
    if (!ext) begin
      case (code)
        CODE_14: bits = 8'h01;
        CODE_12: bits = 8'h02;
        CODE_11: bits = 8'h04;
        CODE_59: bits = 8'h20;
        default: bits = 8'h00;
      endcase
    end else begin
      case (code)
        CODE_1F: bits = 8'h08;
        CODE_14: bits = 8'h10;
        CODE_11: bits = 8'h40;
        CODE_27: bits = 8'h80;
        default: bits = 8'h00;
      endcase
    end
    return bits;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ps2kd_if.sv]
// Valid/ready channel interfaces for scan bytes and decoded key beats.
`default_nettype none
interface ps2kd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

interface ps2kd_out_if;
  logic       valid;
  logic       ready;
  logic       new_key;
  logic [7:0] key_code;
  logic       key_extended;
  logic       key_direct;
  logic [7:0] modifier_mask;

  modport source (output valid, output new_key, output key_code, output key_extended,
                  output key_direct, output modifier_mask, input ready);
  modport sink (input valid, input new_key, input key_code, input key_extended,
                input key_direct, input modifier_mask, output ready);
endinterface
`default_nettype wire

[rtl/core/ps2kd_decode.sv]
// Prefix/sequence state machine with held key and modifier state.
`default_nettype none
module ps2kd_decode
  import ps2kd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] scan_byte,
  output result_t         res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] key_r, key_nxt;
  logic       ext_r, ext_nxt;
  logic       dir_r, dir_nxt;
  logic [7:0] mod_r, mod_nxt;
  logic       new_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      key_r   <= 8'h00;
      ext_r   <= 1'b0;
      dir_r   <= 1'b0;
      mod_r   <= 8'h00;
    end else if (step) begin
      phase_r <= phase_nxt;
      key_r   <= key_nxt;
      ext_r   <= ext_nxt;
      dir_r   <= dir_nxt;
      mod_r   <= mod_nxt;
    end
  end

  always_comb begin
    phase_nxt = PH_IDLE;
    key_nxt   = key_r;
    ext_nxt   = ext_r;
    dir_nxt   = dir_r;
    mod_nxt   = mod_r;
    new_key   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (scan_byte == CODE_E0) begin
          phase_nxt = PH_E0;
        end else if (scan_byte == CODE_F0) begin
          phase_nxt = PH_F0;
        end else if (scan_byte == CODE_E1) begin
          phase_nxt = PH_P1;
        end else if (scan_byte == CODE_F7) begin
          key_nxt = USAGE_F7;
          ext_nxt = 1'b0;
          dir_nxt = 1'b1;
          new_key = 1'b1;
        end else begin
          key_nxt = scan_byte;
          ext_nxt = 1'b0;
          dir_nxt = 1'b0;
          mod_nxt = mod_r | mod_bit_of(scan_byte, 1'b0);
          new_key = 1'b1;
        end
      end
      PH_E0: begin
        if (scan_byte == CODE_12 || scan_byte == CODE_59) begin
          phase_nxt = PH_IDLE;  // fake shift
        end else if (scan_byte == CODE_7E) begin
          phase_nxt = PH_C1;
        end else if (scan_byte == CODE_F0) begin
          phase_nxt = PH_E0F0;
        end else begin
          key_nxt = scan_byte;
          ext_nxt = 1'b1;
          dir_nxt = 1'b0;
          mod_nxt = mod_r | mod_bit_of(scan_byte, 1'b1);
          new_key = 1'b1;
        end
      end
      PH_F0: begin
        key_nxt = 8'h00;
        ext_nxt = 1'b0;
        dir_nxt = 1'b0;
        mod_nxt = mod_r & ~mod_bit_of(scan_byte, 1'b0);
      end
      PH_E0F0: begin
        if (scan_byte != CODE_12 && scan_byte != CODE_59) begin
          key_nxt = 8'h00;
          ext_nxt = 1'b0;
          dir_nxt = 1'b0;
          mod_nxt = mod_r & ~mod_bit_of(scan_byte, 1'b1);
        end
      end
      PH_P1: phase_nxt = (scan_byte == CODE_14) ? PH_P2 : PH_IDLE;
      PH_P2: phase_nxt = (scan_byte == CODE_77) ? PH_P3 : PH_IDLE;
      PH_P3: phase_nxt = (scan_byte == CODE_E1) ? PH_P4 : PH_IDLE;
      PH_P4: phase_nxt = (scan_byte == CODE_F0) ? PH_P5 : PH_IDLE;
      PH_P5: phase_nxt = (scan_byte == CODE_14) ? PH_P6 : PH_IDLE;
      PH_P6: phase_nxt = (scan_byte == CODE_F0) ? PH_P7 : PH_IDLE;
      PH_P7: begin
        if (scan_byte == CODE_77) begin
          key_nxt = USAGE_PAUSE;
          ext_nxt = 1'b0;
          dir_nxt = 1'b1;
          new_key = 1'b1;
        end
      end
      PH_C1: phase_nxt = (scan_byte == CODE_E0) ? PH_C2 : PH_IDLE;
      PH_C2: phase_nxt = (scan_byte == CODE_F0) ? PH_C3 : PH_IDLE;
      PH_C3: begin
        if (scan_byte == CODE_7E) begin
          key_nxt = USAGE_PAUSE;
          ext_nxt = 1'b0;
          dir_nxt = 1'b1;
          new_key = 1'b1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  assign res.new_key       = new_key;
  assign res.key_code      = key_nxt;
  assign res.key_extended  = ext_nxt;
  assign res.key_direct    = dir_nxt;
  assign res.modifier_mask = mod_nxt;

endmodule
`default_nettype wire

[rtl/core/ps2_set2_key_prefix_decoder.sv]
// Top level of the PS/2 scan code set 2 key and prefix decoder.
//
// Channels: in_ch carries one set 2 scan byte per beat; out_ch carries one
// result beat per input beat (new_key, held key code with its extended and
// direct flags, and the HID modifier byte as it stands after that byte).
// Both channels use valid/ready; a beat moves when both are high.
//
// Pipeline: input register -> decode logic -> result register. A byte
// accepted into the input register is decoded and loaded into the result
// register once the result slot is free; out_ch.valid is driven from there.
// Throughput is one byte per cycle while the sink keeps out_ch.ready high, set
// by the decode step that updates the phase, held key and modifier state.
//
// Stall: when the sink holds out_ch.ready low, the result register holds its
// beat and the input register keeps one further byte; in_ch.ready then drops
// until the result is taken. Nothing is dropped or repeated.
//
// Reset (rst_n low, synchronous): both registers empty, phase idle, held
// key and modifier byte cleared.
`default_nettype none
module ps2_set2_key_prefix_decoder
  import ps2kd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  ps2kd_in_if.sink      in_ch,
  ps2kd_out_if.source   out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    dec_res;
  logic       advance;

  // decode fires when a byte is waiting and the result slot is free
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= dec_res;
    end
  end

  ps2kd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .scan_byte (in_byte_r),
    .res       (dec_res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.new_key       = out_res_r.new_key;
  assign out_ch.key_code      = out_res_r.key_code;
  assign out_ch.key_extended  = out_res_r.key_extended;
  assign out_ch.key_direct    = out_res_r.key_direct;
  assign out_ch.modifier_mask = out_res_r.modifier_mask;

endmodule
`default_nettype wire
